// File: sv/mtnw_pkg.sv
package mtnw_pkg;

    // Map grid geometry: the grid is fixed at 16 metatiles across
    localparam int GRID_COLUMNS = 16;
    localparam int ROW_TILES    = 2 * GRID_COLUMNS;

    localparam int ADDR_W = 14;
    localparam int TILE_W = 8;
    localparam int CELL_W = 8;
    localparam int CODE_W = 4;

    localparam logic [ADDR_W-1:0] BASE_RESET = 14'h2000;

    // Input selector codes
    localparam logic FUNC_PLACE = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // Four tiles of one metatile: top-left, top-right, bottom-left, bottom-right
    typedef logic [0:3][TILE_W-1:0] tile_row_t;

    // One expanded metatile waiting for serialization
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        tile_row_t         tiles;
    } item_t;

    localparam tile_row_t TILE_ROM [16] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h01, 8'h02, 8'h02},
        '{8'h0A, 8'h0B, 8'h0A, 8'h0B},
        '{8'h0C, 8'h0D, 8'h0E, 8'h0F},
        '{8'h10, 8'h11, 8'h12, 8'h13},
        '{8'h06, 8'h07, 8'h08, 8'h09},
        '{8'h03, 8'h04, 8'h05, 8'h05},
        '{8'h05, 8'h05, 8'h05, 8'h05},
        '{8'h14, 8'h15, 8'h16, 8'h17},
        '{8'h18, 8'h19, 8'h16, 8'h17},
        '{8'h1A, 8'h1B, 8'h1C, 8'h1D},
        '{8'h1E, 8'h1F, 8'h20, 8'h21},
        '{8'h22, 8'h23, 8'h24, 8'h25},
        '{8'h26, 8'h27, 8'h28, 8'h29},
        '{8'h28, 8'h29, 8'h28, 8'h29},
        '{8'h28, 8'h29, 8'h2A, 8'h2B}
    };

    // Address offset of each tile from the top-left tile
    function automatic logic [ADDR_W-1:0] beat_offset(input logic [1:0] beat);
        logic [ADDR_W-1:0] off;
        case (beat)
            2'd0:    off = '0;
            2'd1:    off = ADDR_W'(1);
            2'd2:    off = ADDR_W'(ROW_TILES);
            2'd3:    off = ADDR_W'(ROW_TILES + 1);
            default: off = '0;
        endcase
        return off;
    endfunction

endpackage

// File: sv/metatile_nametable_writer.sv
// Expands 2x2 metatiles into four video-memory tile writes each (top-left,
// top-right, bottom-left, bottom-right). An input transaction is expanded into
// an item register; the beat stage then sends its four writes through a
// registered output, one per cycle while m_tready holds no write back. The
// next item is taken while the last write of the previous one is still
// going out, and the first write passes the item register and then the
// output register before it is offered. The nametable base resets to 0x2000
// and may be rewritten through cfg_wr_en/cfg_wr_data while the block is idle.
module metatile_nametable_writer
    import mtnw_pkg::*;
#(
    parameter int MAP_CELLS = 240
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data,   // nametable_base
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,       // metatile[3:0], cell_index[11:4], zero fill
    input  logic [1:0]        s_tuser,       // func[0], restart[1]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,       // vram_address[13:0], tile_data[21:14], zero fill
    output logic              m_tlast
);

    logic [ADDR_W-1:0] base_reg;
    logic              item_take;
    logic              item_valid;
    item_t             item;
    logic [ADDR_W-1:0] out_addr;
    logic [TILE_W-1:0] out_tile;

    // Hold the nametable base register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    mtnw_place_stage #(
        .MAP_CELLS (MAP_CELLS)
    ) u_place (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .base       (base_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .func       (s_tuser[0]),
        .restart    (s_tuser[1]),
        .metatile   (s_tdata[3:0]),
        .cell_index (s_tdata[11:4]),
        .item_take  (item_take),
        .item_valid (item_valid),
        .item       (item)
    );

    mtnw_beat_stage u_beat (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_addr   (out_addr),
        .out_tile   (out_tile),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, out_tile, out_addr};

endmodule

// File: sv/mtnw_place_stage.sv
module mtnw_place_stage
    import mtnw_pkg::*;
#(
    parameter int MAP_CELLS = 240
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [ADDR_W-1:0] base,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic              restart,
    input  logic [CODE_W-1:0] metatile,
    input  logic [CELL_W-1:0] cell_index,
    input  logic              item_take,
    output logic              item_valid,
    output item_t             item
);

    localparam logic [CELL_W:0] MAP_LIMIT = (CELL_W+1)'(MAP_CELLS);

    logic [CELL_W-1:0] position_reg, position_next;
    logic              item_valid_reg, item_valid_next;
    item_t             item_reg;

    logic              accept;
    logic [CELL_W-1:0] cur_pos;
    logic [CELL_W-1:0] tgt_cell;
    logic [CELL_W:0]   pos_inc;
    logic [ADDR_W-1:0] cell_off;

    // Take a new transaction when the slot is empty or drains this cycle
    assign in_ready = !item_valid_reg || item_take;
    assign accept   = in_valid && in_ready;

    // Select the cell and advance the running position
    always_comb begin
        cur_pos       = restart ? '0 : position_reg;
        tgt_cell      = (func == FUNC_PLACE) ? cur_pos : cell_index;
        pos_inc       = {1'b0, cur_pos} + (CELL_W+1)'(1);
        position_next = position_reg;
        if (accept && func == FUNC_PLACE) begin
            position_next = (pos_inc >= MAP_LIMIT) ? '0 : pos_inc[CELL_W-1:0];
        end
    end

    // Row times 64 plus column times 2: the fields do not overlap
    assign cell_off = {4'b0000, tgt_cell[7:4], 1'b0, tgt_cell[3:0], 1'b0};

    always_comb begin
        item_valid_next = item_valid_reg;
        if (accept) begin
            item_valid_next = 1'b1;
        end else if (item_take) begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= '0;
            item_valid_reg <= 1'b0;
        end else begin
            position_reg   <= position_next;
            item_valid_reg <= item_valid_next;
        end
    end

    // Hold the expanded metatile for the beat stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.addr  <= base + cell_off;
            item_reg.tiles <= (func == FUNC_PLACE) ? TILE_ROM[metatile] : '0;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    property p_position_in_map;
        @(posedge aclk) disable iff (!aresetn)
            {1'b0, position_reg} < MAP_LIMIT;
    endproperty
    a_position_in_map: assert property (p_position_in_map)
        else $error("running position left the map");

endmodule

// File: sv/mtnw_beat_stage.sv
module mtnw_beat_stage
    import mtnw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  item_t             item,
    output logic              item_take,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] out_addr,
    output logic [TILE_W-1:0] out_tile,
    output logic              out_last
);

    logic [1:0]        beat_reg, beat_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [TILE_W-1:0] out_tile_reg;
    logic              out_last_reg;
    logic              out_load;

    // Load the output register when it is empty or being taken
    assign out_load  = item_valid && (!out_valid_reg || out_ready);
    assign item_take = out_load && (beat_reg == 2'd3);

    always_comb begin
        beat_next      = out_load ? beat_reg + 2'd1 : beat_reg;
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Build one tile write
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_addr_reg <= item.addr + beat_offset(beat_reg);
            out_tile_reg <= item.tiles[beat_reg];
            out_last_reg <= (beat_reg == 2'd3);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_addr  = out_addr_reg;
    assign out_tile  = out_tile_reg;
    assign out_last  = out_last_reg;

    property p_idle_beat_zero;
        @(posedge aclk) disable iff (!aresetn)
            !item_valid |-> beat_reg == 2'd0;
    endproperty
    a_idle_beat_zero: assert property (p_idle_beat_zero)
        else $error("beat counter moved without an item");

    property p_last_loaded;
        @(posedge aclk) disable iff (!aresetn)
            out_load && beat_reg == 2'd3 |=> out_valid_reg && out_last_reg;
    endproperty
    a_last_loaded: assert property (p_last_loaded)
        else $error("fourth write not marked last");

    property p_first_not_last;
        @(posedge aclk) disable iff (!aresetn)
            out_load && beat_reg != 2'd3 |=> out_valid_reg && !out_last_reg;
    endproperty
    a_first_not_last: assert property (p_first_not_last)
        else $error("early write marked last");

endmodule
